// ===== hdl/atp_pkg.sv =====
// shared widths, fixed-point constants and helper functions for the atan2 pipeline
// no dependencies; imported by atp_div, atp_poly, atan2_poly_approx and the bench
package atp_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_W         = ANGLE_FRAC_BITS + 3;

    // magnitude of a sample, most negative value included
    localparam int MAG_W      = SAMPLE_WIDTH;
    // ratio min/max in unsigned q1.16
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_W    = RATIO_FRAC + 1;

    // polynomial datapath in q24
    localparam int Q_INT    = 24;
    localparam int SQ_SHIFT = 2 * RATIO_FRAC - Q_INT;
    localparam int SQ_W     = Q_INT + 1;
    localparam int T_W      = 28;
    localparam int P_W      = 2 * T_W;
    localparam int RND_OUT  = Q_INT - ANGLE_FRAC_BITS;

    // divider: one quotient bit per step, at most DIV_BITS steps per stage
    localparam int DIV_STEPS  = RATIO_W;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = (DIV_STEPS + DIV_BITS - 1) / DIV_BITS;

    localparam int POLY_STAGES = 9;

    localparam int K_C3_INT      = -780081;
    localparam int K_C2_INT      = 2672849;
    localparam int K_C1_INT      = -5496598;
    localparam int K_HALF_PI_INT = 26353590;
    localparam int K_PI_INT      = 52707180;

    localparam logic signed [T_W-1:0] K_C3      = T_W'(K_C3_INT);
    localparam logic signed [T_W-1:0] K_C2      = T_W'(K_C2_INT);
    localparam logic signed [T_W-1:0] K_C1      = T_W'(K_C1_INT);
    localparam logic signed [T_W-1:0] K_HALF_PI = T_W'(K_HALF_PI_INT);
    localparam logic signed [T_W-1:0] K_PI      = T_W'(K_PI_INT);

    // largest output magnitude, pi at the output scale
    localparam int ANGLE_MAX_INT = (K_PI_INT + (1 << (RND_OUT - 1))) >> RND_OUT;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(ANGLE_MAX_INT);

    typedef struct packed {
        logic swap;   // |sin| > |cos|
        logic cneg;   // cos < 0
        logic sneg;   // sin < 0
        logic zero;   // both samples zero
    } t_side;

    // round half up, then drop n fraction bits
    function automatic logic signed [T_W-1:0] rnd_t(input logic signed [P_W-1:0] x,
                                                    input int n);
        logic signed [P_W:0] s;
        s = {x[P_W-1], x} + ((P_W + 1)'(1) << (n - 1));
        return T_W'(s >>> n);
    endfunction

    function automatic logic signed [P_W-1:0] mul_t(input logic signed [T_W-1:0] x,
                                                    input logic signed [T_W-1:0] y);
        logic signed [P_W-1:0] xe;
        logic signed [P_W-1:0] ye;
        xe = P_W'(x);
        ye = P_W'(y);
        return xe * ye;
    endfunction

endpackage

// ===== hdl/atp_div.sv =====
// pipelined restoring divider: ratio = floor(min*2^16/max), up to 2 quotient bits a stage
// depends on atp_pkg
module atp_div
    import atp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [MAG_W-1:0]   i_mn,
    input  logic [MAG_W-1:0]   i_mx,
    input  t_side              i_side,
    output logic               o_vld,
    output logic [RATIO_W-1:0] o_ratio,
    output t_side              o_side
);

    logic               r_vld  [DIV_STAGES];
    logic [MAG_W-1:0]   r_rem  [DIV_STAGES];
    logic [MAG_W-1:0]   r_mx   [DIV_STAGES];
    logic [RATIO_W-1:0] r_q    [DIV_STAGES];
    t_side              r_side [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic               c_vld_in;
        t_side              c_side_in;
        logic [MAG_W-1:0]   c_rem_in;
        logic [MAG_W-1:0]   c_mx_in;
        logic [RATIO_W-1:0] c_q_in;
        logic               c_lsb;
        logic [MAG_W-1:0]   c_rem_out;
        logic [RATIO_W-1:0] c_q_out;

        if (s == 0) begin : g_first
            // the dividend lsb is fed in by the first step so every step shifts alike
            assign c_vld_in  = i_vld;
            assign c_side_in = i_side;
            assign c_rem_in  = {1'b0, i_mn[MAG_W-1:1]};
            assign c_lsb     = i_mn[0];
            assign c_mx_in   = i_mx;
            assign c_q_in    = '0;
        end else begin : g_next
            assign c_vld_in  = r_vld[s-1];
            assign c_side_in = r_side[s-1];
            assign c_rem_in  = r_rem[s-1];
            assign c_lsb     = 1'b0;
            assign c_mx_in   = r_mx[s-1];
            assign c_q_in    = r_q[s-1];
        end

        always_comb begin : p_step
            logic [MAG_W:0]     wide;
            logic [MAG_W-1:0]   rem;
            logic [RATIO_W-1:0] q;
            rem  = c_rem_in;
            q    = c_q_in;
            wide = '0;
            for (int b = 0; b < DIV_BITS; b++) begin
                if (s * DIV_BITS + b < DIV_STEPS) begin
                    wide = {rem, (b == 0) ? c_lsb : 1'b0};
                    if (wide >= {1'b0, c_mx_in}) begin
                        wide = wide - {1'b0, c_mx_in};
                        q    = {q[RATIO_W-2:0], 1'b1};
                    end else begin
                        q    = {q[RATIO_W-2:0], 1'b0};
                    end
                    rem = wide[MAG_W-1:0];
                end
            end
            c_rem_out = rem;
            c_q_out   = q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= c_vld_in;
            end
            r_rem[s]  <= c_rem_out;
            r_mx[s]   <= c_mx_in;
            r_q[s]    <= c_q_out;
            r_side[s] <= c_side_in;
        end
    end

    assign o_vld   = r_vld[DIV_STAGES-1];
    assign o_ratio = r_q[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

// ===== hdl/atp_poly.sv =====
// odd 7th-order arctangent polynomial of the ratio in q24; each stage multiplies, rounds or both
// depends on atp_pkg
module atp_poly
    import atp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [RATIO_W-1:0]    i_ratio,
    input  t_side                 i_side,
    output logic                  o_vld,
    output logic signed [T_W-1:0] o_r,
    output t_side                 o_side
);

    logic               r_vld  [POLY_STAGES];
    t_side              r_side [POLY_STAGES];
    logic [RATIO_W-1:0] r_a    [POLY_STAGES];

    logic [SQ_W-1:0]       r1_sq;
    logic signed [P_W-1:0] r2_m;
    logic signed [T_W-1:0] r3_t;
    logic signed [P_W-1:0] r4_m;
    logic signed [T_W-1:0] r5_t;
    logic signed [P_W-1:0] r6_m;
    logic signed [T_W-1:0] r7_t;
    logic signed [P_W-1:0] r8_m;
    logic signed [T_W-1:0] r9_r;

    // a^2 travels down the chain so each multiply sees the square of its own item
    logic [SQ_W-1:0]       r_sq_d [4];

    logic [2*RATIO_W-1:0]  c_aa;
    logic [SQ_W-1:0]       c_sq;
    logic signed [T_W-1:0] c_sq_e;
    logic signed [T_W-1:0] c_sq4_e;
    logic signed [T_W-1:0] c_sq6_e;
    logic signed [T_W-1:0] c_a8_e;
    logic signed [T_W-1:0] c_a9_e;

    // a^2 rounded to q24
    assign c_aa = (2*RATIO_W)'(i_ratio) * (2*RATIO_W)'(i_ratio);
    assign c_sq = SQ_W'((c_aa + ((2*RATIO_W)'(1) << (SQ_SHIFT - 1))) >> SQ_SHIFT);

    assign c_sq_e  = signed'(T_W'(r1_sq));
    assign c_sq4_e = signed'(T_W'(r_sq_d[1]));
    assign c_sq6_e = signed'(T_W'(r_sq_d[3]));
    assign c_a8_e  = signed'(T_W'(r_a[6]));
    assign c_a9_e  = signed'(T_W'(r_a[7]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POLY_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < POLY_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
        r_side[0] <= i_side;
        r_a[0]    <= i_ratio;
        for (int k = 1; k < POLY_STAGES; k++) begin
            r_side[k] <= r_side[k-1];
            r_a[k]    <= r_a[k-1];
        end

        r_sq_d[0] <= r1_sq;
        for (int k = 1; k < 4; k++) begin
            r_sq_d[k] <= r_sq_d[k-1];
        end

        // horner chain: C3, C2, C1 over a^2, then times a, plus a
        r1_sq <= c_sq;
        r2_m  <= mul_t(K_C3, c_sq_e);
        r3_t  <= rnd_t(r2_m, Q_INT) + K_C2;
        r4_m  <= mul_t(r3_t, c_sq4_e);
        r5_t  <= rnd_t(r4_m, Q_INT) + K_C1;
        r6_m  <= mul_t(r5_t, c_sq6_e);
        r7_t  <= rnd_t(r6_m, Q_INT);
        r8_m  <= mul_t(r7_t, c_a8_e);
        r9_r  <= rnd_t(r8_m, RATIO_FRAC) + (c_a9_e <<< (Q_INT - RATIO_FRAC));
    end

    assign o_vld  = r_vld[POLY_STAGES-1];
    assign o_r    = r9_r;
    assign o_side = r_side[POLY_STAGES-1];

endmodule

// ===== hdl/atan2_poly_approx.sv =====
// four-quadrant arctangent of a sine/cosine pair, angle in signed q3.13 radians
// path: input register, divider stages, polynomial stages, mirror register, output register
// throughput: one beat per cycle with busy tied low; the receiver cannot stall the pipeline
// depth: 9 divider stages (17-bit ratio), 9 polynomial stages (five multiplies), plus 3
// reset: synchronous active-low i_rst_n clears every pipeline valid bit
// depends on atp_pkg, atp_div, atp_poly
module atan2_poly_approx
    import atp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [MAG_W-1:0]   i_sin_val,
    input  logic signed [MAG_W-1:0]   i_cos_val,
    output logic                      o_valid,
    output logic signed [ANGLE_W-1:0] o_angle,
    output logic                      o_zero_input
);

    localparam int LATENCY = 1 + DIV_STAGES + POLY_STAGES + 2;

    logic [MAG_W-1:0] c_as;
    logic [MAG_W-1:0] c_ac;
    t_side            c_side;

    logic             r_f_vld;
    logic [MAG_W-1:0] r_f_mn;
    logic [MAG_W-1:0] r_f_mx;
    t_side            r_f_side;

    logic               d_vld;
    logic [RATIO_W-1:0] d_ratio;
    t_side              d_side;

    logic                  p_vld;
    logic signed [T_W-1:0] p_r;
    t_side                 p_side;

    logic                  r_m_vld;
    logic signed [T_W-1:0] r_m_r;
    t_side                 r_m_side;

    logic signed [T_W-1:0] c_m1;
    logic signed [T_W-1:0] c_m2;
    logic signed [T_W-1:0] c_neg;
    logic signed [T_W:0]   c_sum;

    logic                      r_o_vld;
    logic signed [ANGLE_W-1:0] r_o_angle;
    logic                      r_o_zero;

    assign busy = 1'b0;

    // magnitudes; the most negative sample maps to 2^(width-1) exactly
    assign c_as = i_sin_val[MAG_W-1] ? MAG_W'(-i_sin_val) : MAG_W'(i_sin_val);
    assign c_ac = i_cos_val[MAG_W-1] ? MAG_W'(-i_cos_val) : MAG_W'(i_cos_val);

    assign c_side.swap = c_as > c_ac;
    assign c_side.cneg = i_cos_val[MAG_W-1];
    assign c_side.sneg = i_sin_val[MAG_W-1];
    assign c_side.zero = (c_as == '0) && (c_ac == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= start && !busy;
        end
        r_f_mn   <= c_side.swap ? c_ac : c_as;
        r_f_mx   <= c_side.swap ? c_as : c_ac;
        r_f_side <= c_side;
    end

    atp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_f_vld),
        .i_mn    (r_f_mn),
        .i_mx    (r_f_mx),
        .i_side  (r_f_side),
        .o_vld   (d_vld),
        .o_ratio (d_ratio),
        .o_side  (d_side)
    );

    atp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d_vld),
        .i_ratio (d_ratio),
        .i_side  (d_side),
        .o_vld   (p_vld),
        .o_r     (p_r),
        .o_side  (p_side)
    );

    // octant then half-plane mirror
    assign c_m1 = p_side.swap ? (K_HALF_PI - p_r) : p_r;
    assign c_m2 = p_side.cneg ? (K_PI - c_m1) : c_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= p_vld;
        end
        r_m_r    <= c_m2;
        r_m_side <= p_side;
    end

    assign c_neg = r_m_side.sneg ? -r_m_r : r_m_r;
    assign c_sum = {c_neg[T_W-1], c_neg} + ((T_W + 1)'(1) << (RND_OUT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_m_vld;
        end
        r_o_angle <= r_m_side.zero ? '0 : ANGLE_W'(c_sum >>> RND_OUT);
        r_o_zero  <= r_m_side.zero;
    end

    assign o_valid      = r_o_vld;
    assign o_angle      = r_o_angle;
    assign o_zero_input = r_o_zero;

`ifndef SYNTHESIS
    a_zero_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_sin_val == '0 && i_cos_val == '0
        |-> ##LATENCY o_valid && o_zero_input && o_angle == '0)
        else $error("zero input pair did not give a flagged zero angle");

    a_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("accepted beat did not come out after the pipeline latency");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angle <= ANGLE_MAX && o_angle >= -ANGLE_MAX)
        else $error("angle outside -pi..pi");
`endif

endmodule

// ===== bench/tb_atan2_poly_approx.sv =====
// self-checking bench for atan2_poly_approx: directed corner pairs, then random bursts
// predicts each angle in q24 fixed point and compares every o_valid beat in order
// depends on atp_pkg and the atan2_poly_approx rtl
module tb_atan2_poly_approx;
    import atp_pkg::*;

    localparam int NUM_RANDOM  = 1550;
    localparam int IDLE_LIMIT  = 500;
    localparam int DRAIN_WAIT  = 30;
    localparam int PRINT_LIMIT = 20;

    typedef logic signed [MAG_W-1:0] t_sample;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic                      zero;
    } t_angle_beat;

    class angle_scoreboard;
        t_angle_beat pending_angles[$];
        int          mismatches;
        int          pairs_in;
        int          beats_out;
        int          zero_pairs;
        int          swapped_pairs;

        function new();
            mismatches    = 0;
            pairs_in      = 0;
            beats_out     = 0;
            zero_pairs    = 0;
            swapped_pairs = 0;
        endfunction

        // round half up, also for negative values
        function automatic longint round_shift(longint x, int n);
            return (x + (longint'(1) << (n - 1))) >>> n;
        endfunction

        function automatic t_angle_beat quadrant_angle(t_sample s, t_sample c);
            t_angle_beat res;
            longint sv, cv, as, ac, mn, mx, a, sq, t, r;
            sv = s;
            cv = c;
            as = (sv < 0) ? -sv : sv;
            ac = (cv < 0) ? -cv : cv;
            mn = (as < ac) ? as : ac;
            mx = (as < ac) ? ac : as;
            if (mx == 0) begin
                res.angle = '0;
                res.zero  = 1'b1;
                return res;
            end
            a  = (mn << RATIO_FRAC) / mx;
            sq = round_shift(a * a, 2 * RATIO_FRAC - Q_INT);
            t  = round_shift(longint'(K_C3_INT) * sq, Q_INT) + K_C2_INT;
            t  = round_shift(t * sq, Q_INT) + K_C1_INT;
            t  = round_shift(t * sq, Q_INT);
            t  = round_shift(t * a, RATIO_FRAC);
            r  = t + (a << (Q_INT - RATIO_FRAC));
            if (as > ac)
                r = K_HALF_PI_INT - r;
            if (cv < 0)
                r = K_PI_INT - r;
            if (sv < 0)
                r = -r;
            res.angle = ANGLE_W'(round_shift(r, Q_INT - ANGLE_FRAC_BITS));
            res.zero  = 1'b0;
            return res;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("mismatch @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_pair(t_sample s, t_sample c);
            t_angle_beat exp_beat;
            exp_beat = quadrant_angle(s, c);
            pending_angles.push_back(exp_beat);
            pairs_in++;
            if (exp_beat.zero)
                zero_pairs++;
            if ((s < 0 ? -int'(s) : int'(s)) > (c < 0 ? -int'(c) : int'(c)))
                swapped_pairs++;
        endfunction

        task check_angle(logic signed [ANGLE_W-1:0] angle, logic zero);
            t_angle_beat exp_beat;
            beats_out++;
            if (pending_angles.size() == 0) begin
                report_mismatch($sformatf("unexpected beat angle=%0d zero=%b", angle, zero));
                return;
            end
            exp_beat = pending_angles.pop_front();
            if (angle !== exp_beat.angle)
                report_mismatch($sformatf("beat %0d angle %0d, expected %0d",
                                          beats_out, angle, exp_beat.angle));
            if (zero !== exp_beat.zero)
                report_mismatch($sformatf("beat %0d zero_input %b, expected %b",
                                          beats_out, zero, exp_beat.zero));
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    t_sample                   i_sin_val;
    t_sample                   i_cos_val;
    logic                      o_valid;
    logic signed [ANGLE_W-1:0] o_angle;
    logic                      o_zero_input;

    angle_scoreboard sb = new();
    int              idle_cycles = 0;

    atan2_poly_approx dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sin_val    (i_sin_val),
        .i_cos_val    (i_cos_val),
        .o_valid      (o_valid),
        .o_angle      (o_angle),
        .o_zero_input (o_zero_input)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // sample at the rising edge; inputs only move at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1)
                sb.check_angle(o_angle, o_zero_input);
            else if (o_valid !== 1'b0)
                sb.report_mismatch("o_valid is unknown");
            if (start && !busy)
                sb.note_pair(i_sin_val, i_cos_val);
            if (o_valid === 1'b1 || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d pending",
                     IDLE_LIMIT, sb.pending_angles.size());
            $display("** atan2_poly_approx: FAILED **");
            $finish;
        end
    end

    // holds start high across back-to-back calls; one beat per call
    task automatic send_pair(t_sample s, t_sample c);
        @(negedge i_clk);
        start     <= 1'b1;
        i_sin_val <= s;
        i_cos_val <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start     <= 1'b0;
            i_sin_val <= t_sample'($urandom);
            i_cos_val <= t_sample'($urandom);
        end
    endtask

    initial begin
        int      extreme_vals[6];
        int      sent;
        int      burst;
        int      kind;
        int      m;
        int      d;
        t_sample s;
        t_sample c;
        t_sample tmp;

        extreme_vals = '{-32768, -32767, -1, 0, 1, 32767};
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_sin_val = '0;
        i_cos_val = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners: zero pair, axes, equal and near-equal magnitudes, most negative samples
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, 16'sd32767);
        send_pair(16'sd0, -16'sd32768);
        send_pair(16'sd0, -16'sd1);
        send_pair(16'sd32767, 16'sd0);
        send_pair(-16'sd32768, 16'sd0);
        send_pair(16'sd1, 16'sd0);
        send_pair(-16'sd1, 16'sd0);
        send_pair(16'sd0, 16'sd1);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(16'sd32767, 16'sd32767);
        send_pair(16'sd32767, -16'sd32767);
        send_pair(-16'sd32767, 16'sd32767);
        send_pair(-16'sd32768, 16'sd32767);
        send_pair(16'sd32767, -16'sd32768);
        send_pair(-16'sd32768, -16'sd32767);
        send_pair(16'sd1, 16'sd1);
        send_pair(-16'sd1, -16'sd1);
        send_pair(16'sd1, -16'sd1);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sd100, 16'sd101);
        send_pair(16'sd101, -16'sd100);
        idle($urandom_range(1, 5));

        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(0, 7) == 0 ? $urandom_range(60, 120)
                                              : $urandom_range(1, 30);
            for (int k = 0; k < burst && sent < NUM_RANDOM; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    s = t_sample'($urandom);
                    c = t_sample'($urandom);
                end else if (kind < 70) begin
                    s = t_sample'(int'($urandom_range(0, 32)) - 16);
                    c = t_sample'(int'($urandom_range(0, 32)) - 16);
                end else if (kind < 85) begin
                    // near the diagonal, where the pi/2 mirror flips
                    m = $urandom_range(0, 32768);
                    d = $urandom_range(0, 3);
                    s = t_sample'($urandom_range(0, 1) ? -m : m);
                    c = t_sample'(($urandom_range(0, 1) ? -1 : 1) * (m > d ? m - d : 0));
                    if ($urandom_range(0, 1)) begin
                        tmp = s;
                        s   = c;
                        c   = tmp;
                    end
                end else if (kind < 92) begin
                    s = t_sample'($urandom);
                    c = '0;
                    if ($urandom_range(0, 1)) begin
                        c = s;
                        s = '0;
                    end
                end else begin
                    s = t_sample'(extreme_vals[$urandom_range(0, 5)]);
                    c = t_sample'(extreme_vals[$urandom_range(0, 5)]);
                end
                send_pair(s, c);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 12));
        end
        idle(1);

        while (sb.pending_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.pending_angles.size() != 0)
            sb.report_mismatch($sformatf("%0d beats never came", sb.pending_angles.size()));

        $display("covered %0d pairs (%0d zero, %0d with |sin| > |cos|), %0d beats checked",
                 sb.pairs_in, sb.zero_pairs, sb.swapped_pairs, sb.beats_out);
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("** atan2_poly_approx: PASSED **");
        else
            $display("** atan2_poly_approx: FAILED **");
        $finish;
    end

endmodule
